// ----- hw/rtl/mkvt_pkg.sv -----
// package for the multimap key/value table
// holds default sizes, request action codes and result status codes
// no dependencies
package mkvt_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DEF_COUNT_WIDTH = $clog2(DEF_TABLE_DEPTH + 1);

   localparam int ACTION_WIDTH = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_FIND   = 2'd2;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_MATCH     = 2'd3
   } status_type;

endpackage

// ----- hw/rtl/mkvt_if.sv -----
// request and result channel interfaces for the multimap key/value table
// depends on mkvt_pkg
interface mkvt_req_if #(
   parameter int KEY_WIDTH   = mkvt_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = mkvt_pkg::DEF_VALUE_WIDTH
);
   logic                                   valid;
   logic                                   ready;
   logic [mkvt_pkg::ACTION_WIDTH-1:0]      action;
   logic signed [KEY_WIDTH-1:0]            lookup_key;
   logic [VALUE_WIDTH-1:0]                 entry_value;

   modport source (output valid, output action, output lookup_key, output entry_value,
                   input ready);
   modport sink   (input valid, input action, input lookup_key, input entry_value,
                   output ready);
endinterface

interface mkvt_rsp_if #(
   parameter int VALUE_WIDTH = mkvt_pkg::DEF_VALUE_WIDTH,
   parameter int COUNT_WIDTH = mkvt_pkg::DEF_COUNT_WIDTH
);
   logic                      valid;
   logic                      ready;
   mkvt_pkg::status_type      status;
   logic [VALUE_WIDTH-1:0]    found_value;
   logic [COUNT_WIDTH-1:0]    removed_count;
   logic                      last;

   modport source (output valid, output status, output found_value, output removed_count,
                   output last, input ready);
   modport sink   (input valid, input status, input found_value, input removed_count,
                   input last, output ready);
endinterface

// ----- hw/rtl/multimap_key_value_table.sv -----
// multimap key/value table: bounded, insertion-ordered, duplicate keys allowed
// depends on mkvt_pkg and the channel interfaces in mkvt_if
//
// An add, or an unused action code, is answered with one result.
// A remove or a find scans the stored entries through the single read port of the entry
// memory, one entry a cycle, and a find also waits whenever a match result cannot be
// handed on. The final result is loaded in the finish state after the scan, and the next
// request can be taken once the sequencer is back in idle. A find emits its matches oldest
// first and marks the final one; a remove compacts the table in the same pass. A new
// request is taken only once the previous one is finished and the result register can
// take a result.
module multimap_key_value_table #(
   parameter int TABLE_DEPTH = mkvt_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = mkvt_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = mkvt_pkg::DEF_VALUE_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   mkvt_req_if.sink      req_if,
   mkvt_rsp_if.source    rsp_if
);
   import mkvt_pkg::*;

   localparam int PTR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   entry_type entry_mem [TABLE_DEPTH];

   state_type                 state_ff, state_in;
   logic [ACTION_WIDTH-1:0]   op_ff, op_in;
   logic [KEY_WIDTH-1:0]      key_ff, key_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          kept_ff, kept_in;
   logic [CNT_W-1:0]          removed_ff, removed_in;
   logic                      s1_vld_ff, s1_vld_in;
   entry_type                 s1_ff;
   logic                      pend_vld_ff, pend_vld_in;
   logic [VALUE_WIDTH-1:0]    pend_val_ff, pend_val_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0]    rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]          rsp_removed_ff, rsp_removed_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_load;
   logic                      slot_free;
   logic                      req_fire;
   logic                      s1_hit;
   logic                      is_find;
   logic                      stall;
   logic                      issue;
   logic                      scan_end;
   logic                      table_full;
   logic                      mem_we;
   logic [PTR_W-1:0]          mem_wa;
   entry_type                 mem_wd;

   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire     = req_if.valid && req_if.ready;
   assign table_full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign is_find      = (op_ff == ACT_FIND);
   assign s1_hit       = s1_vld_ff && (s1_ff.key == key_ff);
   assign stall        = (state_ff == ST_SCAN) && is_find && s1_hit && pend_vld_ff
                         && !slot_free;
   assign issue        = (state_ff == ST_SCAN) && !stall && (rd_ptr_ff < count_ff);
   assign scan_end     = (state_ff == ST_SCAN) && !s1_vld_ff && (rd_ptr_ff == count_ff);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.found_value   = rsp_value_ff;
   assign rsp_if.removed_count = rsp_removed_ff;
   assign rsp_if.last          = rsp_last_ff;

   // memory write port: append on add, compaction on remove
   always_comb begin
      mem_we = 1'b0;
      mem_wa = count_ff[PTR_W-1:0];
      mem_wd = '{key: KEY_WIDTH'(req_if.lookup_key), value: req_if.entry_value};
      if (req_fire && (req_if.action == ACT_ADD) && !table_full) begin
         mem_we = 1'b1;
      end else if ((state_ff == ST_SCAN) && !is_find && s1_vld_ff && !s1_hit) begin
         mem_we = 1'b1;
         mem_wa = kept_ff[PTR_W-1:0];
         mem_wd = s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      if (issue) begin
         s1_ff <= entry_mem[rd_ptr_ff[PTR_W-1:0]];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      kept_in       = kept_ff;
      removed_in    = removed_ff;
      s1_vld_in     = 1'b0;
      pend_vld_in   = pend_vld_ff;
      pend_val_in   = pend_val_ff;
      out_load      = 1'b0;
      rsp_status_in = STAT_DONE;
      rsp_value_in  = '0;
      rsp_removed_in = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_if.action;
               key_in = KEY_WIDTH'(req_if.lookup_key);
               unique case (req_if.action)
                  ACT_ADD: begin
                     out_load = 1'b1;
                     if (table_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_REMOVE, ACT_FIND: begin
                     state_in    = ST_SCAN;
                     rd_ptr_in   = '0;
                     kept_in     = '0;
                     removed_in  = '0;
                     pend_vld_in = 1'b0;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               s1_vld_in = 1'b1;
            end else if (stall) begin
               s1_vld_in = s1_vld_ff;
            end
            if (s1_vld_ff && !stall) begin
               if (is_find) begin
                  if (s1_hit) begin
                     if (pend_vld_ff) begin
                        out_load      = 1'b1;
                        rsp_status_in = STAT_MATCH;
                        rsp_value_in  = pend_val_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_vld_in = 1'b1;
                     pend_val_in = s1_ff.value;
                  end
               end else if (s1_hit) begin
                  removed_in = removed_ff + CNT_W'(1);
               end else begin
                  kept_in = kept_ff + CNT_W'(1);
               end
            end
            if (scan_end) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (is_find) begin
                  if (pend_vld_ff) begin
                     rsp_status_in = STAT_MATCH;
                     rsp_value_in  = pend_val_ff;
                  end else begin
                     rsp_status_in = STAT_NOT_FOUND;
                  end
               end else begin
                  rsp_removed_in = removed_ff;
                  count_in       = kept_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         s1_vld_ff    <= s1_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      rd_ptr_ff   <= rd_ptr_in;
      kept_ff     <= kept_in;
      removed_ff  <= removed_in;
      pend_val_ff <= pend_val_in;
      if (out_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

endmodule

// ----- hw/rtl/mkvt_checker.sv -----
// port checker for the multimap key/value table, attached by bind
// depends on mkvt_pkg and multimap_key_value_table
module mkvt_checker #(
   parameter int VALUE_WIDTH = mkvt_pkg::DEF_VALUE_WIDTH,
   parameter int COUNT_WIDTH = mkvt_pkg::DEF_COUNT_WIDTH
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mkvt_pkg::status_type     rsp_status,
   input logic [VALUE_WIDTH-1:0]   rsp_found_value,
   input logic [COUNT_WIDTH-1:0]   rsp_removed_count,
   input logic                     rsp_last
);
   import mkvt_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_status) && $stable(rsp_found_value)
         && $stable(rsp_removed_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // only a match may be followed by more results of the same request
   a_last_nonmatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_MATCH) |-> rsp_last)
      else $error("non-match result without last");

   // only a match carries a value, only a remove carries a count
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_MATCH) |-> (rsp_found_value == '0))
      else $error("value on a non-match result");

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STAT_MATCH) || (rsp_status == STAT_FULL)
         || (rsp_status == STAT_NOT_FOUND)) |-> (rsp_removed_count == '0))
      else $error("removed count on a non-remove result");

   // no request is taken while a non-final match result waits
   a_no_accept_mid_find: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !(req_valid && req_ready))
      else $error("request taken in the middle of a find");

endmodule

bind multimap_key_value_table mkvt_checker #(
   .VALUE_WIDTH (VALUE_WIDTH),
   .COUNT_WIDTH ($clog2(TABLE_DEPTH + 1))
) u_mkvt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_found_value   (rsp_if.found_value),
   .rsp_removed_count (rsp_if.removed_count),
   .rsp_last          (rsp_if.last)
);
